/* hw/rtl/nfa_word_matcher_unit_macros.svh */
// Assertion macros for the word matcher.
`ifndef NFA_WORD_MATCHER_UNIT_MACROS_SVH
`define NFA_WORD_MATCHER_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define NWM_ASSERT_IMP(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
        else $error("assertion failed");
`define NWM_ASSERT_NXT(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define NWM_ASSERT_IMP(label, clk, rstn, a, c)
`define NWM_ASSERT_NXT(label, clk, rstn, a, c)
`endif
`endif

/* hw/rtl/nwm_pkg.sv */
// ----------------------------------------------------------------------------
// nwm_pkg
// Shared types and constants of the word matcher.
// ----------------------------------------------------------------------------
package nwm_pkg;
    localparam int MAX_STATES      = 32;
    localparam int MAX_TRANSITIONS = 256;
    localparam int SW  = 5;
    localparam int TW  = $clog2(MAX_TRANSITIONS);
    localparam int CW  = TW + 1;
    localparam int EW  = 19;
    localparam int QD  = 2;

    localparam logic [2:0] ACT_CLEAR = 3'd0;
    localparam logic [2:0] ACT_ADD   = 3'd1;
    localparam logic [2:0] ACT_BEGIN = 3'd2;
    localparam logic [2:0] ACT_FEED  = 3'd3;
    localparam logic [2:0] ACT_END   = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic [1:0] OP_NONE  = 2'd0;
    localparam logic [1:0] OP_BEGIN = 2'd1;
    localparam logic [1:0] OP_FEED  = 2'd2;
    localparam logic [1:0] OP_END   = 2'd3;

    localparam logic [1:0] REG_COUNT = 2'd0;
    localparam logic [1:0] REG_START = 2'd1;
    localparam logic [1:0] REG_FINAL = 2'd2;

    typedef struct packed {
        logic [1:0] op;
        logic [1:0] status;
        logic [7:0] symbol;
    } cmd_t;
endpackage

/* hw/rtl/nwm_ram.sv */
// ----------------------------------------------------------------------------
// nwm_ram
// Generic simple dual-port RAM (one write port, one read port) with registered read.
// ----------------------------------------------------------------------------
module nwm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

/* hw/rtl/nwm_front.sv */
// ----------------------------------------------------------------------------
// nwm_front
// Accepts items, handles table loads, queues a command per item for the back end.
// ----------------------------------------------------------------------------
`include "nfa_word_matcher_unit_macros.svh"
module nwm_front import nwm_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic [2:0]    s_action,
    input  logic [SW-1:0] s_from_state,
    input  logic [SW-1:0] s_to_state,
    input  logic [7:0]    s_symbol,
    input  logic          s_is_epsilon,
    input  logic [5:0]    n_eff,
    input  logic          back_busy,
    output logic          we,
    output logic [TW-1:0] waddr,
    output logic [EW-1:0] wdata,
    output logic [CW-1:0] tcount,
    output logic          q_valid,
    output cmd_t          q_cmd,
    input  logic          q_ready
);
    cmd_t         q_mem_reg [QD];
    logic         wp_reg, rp_reg;
    logic [1:0]   cnt_reg;
    logic [CW-1:0] tcount_reg;
    logic         acc, push, pop;
    logic         bad;
    cmd_t         cmd;

    // every item, table writes included, waits until the back end is not scanning and the queue is empty
    assign s_ready = (cnt_reg != 2'(QD)) && !(back_busy || cnt_reg != 2'd0);
    assign acc     = s_valid && s_ready;
    assign bad     = ({1'b0, s_from_state} >= n_eff) || ({1'b0, s_to_state} >= n_eff);

    always_comb begin
        cmd        = '0;
        cmd.symbol = s_symbol;
        we         = 1'b0;
        unique case (s_action)
            ACT_CLEAR: cmd.op = OP_NONE;
            ACT_ADD: begin
                cmd.op = OP_NONE;
                if (bad) cmd.status = ST_RANGE;
                else if (tcount_reg == CW'(MAX_TRANSITIONS)) cmd.status = ST_FULL;
                else we = acc;
            end
            ACT_BEGIN: cmd.op = OP_BEGIN;
            ACT_FEED:  cmd.op = OP_FEED;
            ACT_END:   cmd.op = OP_END;
            default:   cmd.op = OP_NONE;
        endcase
    end

    assign waddr  = tcount_reg[TW-1:0];
    assign wdata  = {s_from_state, s_to_state, s_symbol, s_is_epsilon};
    assign tcount = tcount_reg;
    assign push   = acc;
    assign pop    = q_valid && q_ready;
    assign q_valid = cnt_reg != 2'd0;
    assign q_cmd   = q_mem_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (push) q_mem_reg[wp_reg] <= cmd;
        if (!aresetn) begin
            wp_reg <= 1'b0; rp_reg <= 1'b0; cnt_reg <= 2'd0; tcount_reg <= '0;
        end else begin
            if (push) wp_reg <= ~wp_reg;
            if (pop)  rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
            if (acc && s_action == ACT_CLEAR) tcount_reg <= '0;
            else if (we) tcount_reg <= tcount_reg + 1'b1;
        end
    end

    `NWM_ASSERT_IMP(a_no_overflow, aclk, aresetn, push, cnt_reg != 2'(QD))
    `NWM_ASSERT_IMP(a_count_cap, aclk, aresetn, 1'b1, tcount_reg <= CW'(MAX_TRANSITIONS))
    `NWM_ASSERT_NXT(a_write_adv, aclk, aresetn, we, tcount_reg == $past(tcount_reg) + 1'b1)
endmodule

/* hw/rtl/nwm_back.sv */
// ----------------------------------------------------------------------------
// nwm_back
// Runs closure and move sweeps over the table, holds the active set, emits results.
// ----------------------------------------------------------------------------
`include "nfa_word_matcher_unit_macros.svh"
module nwm_back import nwm_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          q_valid,
    input  cmd_t          q_cmd,
    output logic          q_ready,
    input  logic [CW-1:0] tcount,
    input  logic [5:0]    n_eff,
    input  logic [SW-1:0] start_state,
    input  logic [31:0]   final_mask,
    output logic [TW-1:0] raddr,
    input  logic [EW-1:0] rdata,
    output logic          busy,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [1:0]    m_status,
    output logic          m_word_done,
    output logic          m_accepted,
    output logic          m_word_alive
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CLO  = 2'd1;
    localparam logic [1:0] S_MOVE = 2'd2;

    logic [1:0]    state_reg, state_next;
    cmd_t          cmd_reg;
    logic [31:0]   set_reg, set_next, nxt_reg, nxt_next, active_reg, active_next;
    logic          changed_reg, changed_next, dead_reg, dead_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic          rv_reg, rv_next;
    logic [31:0]   vm;
    logic          out_valid_reg, out_next_v;
    logic [1:0]    st_reg, st_next;
    logic          done_reg, done_next, acc_reg, acc_next, alive_reg, alive_next;
    logic [SW-1:0] ef, et;
    logic [7:0]    el;
    logic          ee;
    logic          take;

    assign vm = (n_eff >= 6'd32) ? 32'hFFFF_FFFF : ((32'd1 << n_eff[4:0]) - 32'd1);
    assign {ef, et, el, ee} = rdata;
    assign raddr  = idx_reg[TW-1:0];
    assign busy   = state_reg != S_IDLE;
    assign q_ready = state_reg == S_IDLE && (!out_valid_reg || m_ready);
    assign take   = q_valid && q_ready;
    assign m_valid = out_valid_reg;
    assign m_status = st_reg;
    assign m_word_done = done_reg;
    assign m_accepted = acc_reg;
    assign m_word_alive = alive_reg;

    always_comb begin
        state_next = state_reg; set_next = set_reg; nxt_next = nxt_reg;
        active_next = active_reg; dead_next = dead_reg; changed_next = changed_reg;
        idx_next = idx_reg; rv_next = 1'b0;
        out_next_v = out_valid_reg && !m_ready;
        st_next = st_reg; done_next = done_reg; acc_next = acc_reg; alive_next = alive_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (take) begin
                    idx_next = '0; changed_next = 1'b0; nxt_next = '0;
                    set_next = active_reg & vm;
                    priority if (q_cmd.op == OP_BEGIN && {1'b0, start_state} >= n_eff) begin
                        active_next = '0; dead_next = 1'b1;
                        out_next_v = 1'b1; st_next = ST_RANGE; done_next = 1'b0;
                        acc_next = 1'b0; alive_next = 1'b0;
                    end else if (q_cmd.op == OP_BEGIN) begin
                        set_next = (32'd1 << start_state) & vm; state_next = S_CLO;
                    end else if (q_cmd.op == OP_FEED && dead_reg) begin
                        out_next_v = 1'b1; st_next = ST_OK; done_next = 1'b0;
                        acc_next = 1'b0; alive_next = 1'b0;
                    end else if (q_cmd.op == OP_FEED || q_cmd.op == OP_END) begin
                        state_next = S_CLO;
                    end else begin
                        out_next_v = 1'b1; st_next = q_cmd.status; done_next = 1'b0;
                        acc_next = 1'b0; alive_next = !dead_reg && (active_reg & vm) != 0;
                    end
                end
            end
            S_CLO, S_MOVE: begin
                if (rv_reg) begin
                    if (state_reg == S_CLO) begin
                        if (ee && set_reg[ef] && !set_reg[et] && vm[et]) begin
                            set_next[et] = 1'b1; changed_next = 1'b1;
                        end
                    end else if (!ee && el == cmd_reg.symbol && set_reg[ef]) begin
                        nxt_next[et] = 1'b1;
                    end
                end
                if (idx_reg < tcount && !(rv_reg && idx_reg == tcount)) begin
                    idx_next = idx_reg + 1'b1; rv_next = 1'b1;
                end else if (!rv_reg) begin
                    idx_next = '0;
                    if (state_reg == S_CLO && changed_reg) begin
                        changed_next = 1'b0;
                    end else if (state_reg == S_CLO && cmd_reg.op == OP_FEED) begin
                        state_next = S_MOVE;
                    end else begin
                        state_next = S_IDLE; out_next_v = 1'b1; st_next = ST_OK;
                        done_next = 1'b0; acc_next = 1'b0;
                        unique case (cmd_reg.op)
                            OP_BEGIN: begin
                                active_next = set_reg; dead_next = 1'b0;
                                alive_next = set_reg != 0;
                            end
                            OP_FEED: begin
                                active_next = nxt_reg & vm;
                                if ((nxt_reg & vm) == 0) dead_next = 1'b1;
                                alive_next = (nxt_reg & vm) != 0;
                            end
                            default: begin
                                done_next = 1'b1;
                                acc_next = !dead_reg && (set_reg & final_mask) != 0;
                                alive_next = !dead_reg && (active_reg & vm) != 0;
                            end
                        endcase
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (take) cmd_reg <= q_cmd;
        set_reg <= set_next; nxt_reg <= nxt_next; idx_reg <= idx_next;
        changed_reg <= changed_next;
        st_reg <= st_next; done_reg <= done_next; acc_reg <= acc_next;
        alive_reg <= alive_next;
        if (!aresetn) begin
            state_reg <= S_IDLE; active_reg <= '0; dead_reg <= 1'b0;
            out_valid_reg <= 1'b0; rv_reg <= 1'b0;
        end else begin
            state_reg <= state_next; active_reg <= active_next; dead_reg <= dead_next;
            out_valid_reg <= out_next_v; rv_reg <= rv_next;
        end
    end

    `NWM_ASSERT_IMP(a_hold, aclk, aresetn, m_valid && !m_ready, q_ready == 1'b0)
    `NWM_ASSERT_IMP(a_acc_done, aclk, aresetn, m_valid && m_accepted, m_word_done)
    `NWM_ASSERT_NXT(a_busy_nopop, aclk, aresetn, busy, !take)
endmodule

/* hw/rtl/nfa_word_matcher_unit.sv */
// ----------------------------------------------------------------------------
// nfa_word_matcher_unit
// Epsilon-NFA word matcher with a loadable transition table.
// ----------------------------------------------------------------------------
// Input channel s_*: one item per action (clear, add transition, begin word,
// feed symbol, end word). Result channel m_*: exactly one item per input
// item, in order. Configuration is written via cfg_we/cfg_index/cfg_data.
// Table loads are checked and stored by the front end in the cycle in which
// they are accepted; word commands pass a two-entry queue to the back end,
// which sweeps the table through one RAM read port, one entry per cycle. A
// closure sweeps the table once and once more for each growth pass that
// added a state; a feed symbol adds one more sweep. Loads are accepted only
// when the back end is idle. Reset clears the transition count, the active
// set and the dead flag; the table RAM itself is not cleared. When m_ready
// is low the result is held and no new word command is started.
// ----------------------------------------------------------------------------
`include "nfa_word_matcher_unit_macros.svh"
module nfa_word_matcher_unit import nwm_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_we,
    input  logic [1:0]    cfg_index,
    input  logic [31:0]   cfg_data,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic [2:0]    s_action,
    input  logic [4:0]    s_from_state,
    input  logic [4:0]    s_to_state,
    input  logic [7:0]    s_symbol,
    input  logic          s_is_epsilon,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [1:0]    m_status,
    output logic          m_word_done,
    output logic          m_accepted,
    output logic          m_word_alive
);
    logic [5:0]    count_reg;
    logic [SW-1:0] start_reg;
    logic [31:0]   final_reg;
    logic [5:0]    n_eff;
    logic          we, busy, q_valid, q_ready;
    logic [TW-1:0] waddr, raddr;
    logic [EW-1:0] wdata, rdata;
    logic [CW-1:0] tcount;
    cmd_t          q_cmd;

    assign n_eff = (count_reg == 6'd0) ? 6'd1 :
                   (count_reg > 6'(MAX_STATES)) ? 6'(MAX_STATES) : count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 6'd1; start_reg <= '0; final_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_COUNT: count_reg <= cfg_data[5:0];
                REG_START: start_reg <= cfg_data[4:0];
                REG_FINAL: final_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    nwm_front u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_action, .s_from_state, .s_to_state,
        .s_symbol, .s_is_epsilon, .n_eff, .back_busy(busy), .we, .waddr, .wdata,
        .tcount, .q_valid, .q_cmd, .q_ready
    );

    nwm_ram #(.WIDTH(EW), .DEPTH(MAX_TRANSITIONS)) u_table (
        .aclk, .we, .waddr, .wdata, .raddr, .rdata
    );

    nwm_back u_back (
        .aclk, .aresetn, .q_valid, .q_cmd, .q_ready, .tcount, .n_eff,
        .start_state(start_reg), .final_mask(final_reg), .raddr, .rdata, .busy,
        .m_valid, .m_ready, .m_status, .m_word_done, .m_accepted, .m_word_alive
    );

    `NWM_ASSERT_IMP(a_neff, aclk, aresetn, 1'b1, n_eff != 6'd0)
    `NWM_ASSERT_IMP(a_load_idle, aclk, aresetn, we, !busy)
    `NWM_ASSERT_IMP(a_status, aclk, aresetn, m_valid, m_status != 2'd3)
endmodule

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the epsilon-NFA word matcher: builds random automata through
// add-transition items, runs words over them and checks every result item
// against a cycle-free model of the matcher, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_top;
    import nwm_pkg::*;

    typedef struct {
        logic [2:0] action;
        logic [4:0] from_state;
        logic [4:0] to_state;
        logic [7:0] symbol;
        logic       is_epsilon;
    } cmd_item_t;

    typedef struct {
        logic [1:0] status;
        logic       word_done;
        logic       accepted;
        logic       word_alive;
    } res_item_t;

    localparam int WATCHDOG_LIMIT = 200000;
    localparam int DRAIN_CYCLES   = 40000;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic [2:0]  s_action;
    logic [4:0]  s_from_state;
    logic [4:0]  s_to_state;
    logic [7:0]  s_symbol;
    logic        s_is_epsilon;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_status;
    logic        m_word_done;
    logic        m_accepted;
    logic        m_word_alive;

    nfa_word_matcher_unit u_dut (.*);

    // matcher model state
    logic [18:0] trans_store [MAX_TRANSITIONS];
    int unsigned trans_count;
    logic [31:0] active_states;
    logic        word_killed;
    logic [5:0]  cfg_state_count;
    logic [4:0]  cfg_start_state;
    logic [31:0] cfg_final_mask;

    cmd_item_t   pending_cmds[$];
    res_item_t   expected_results[$];
    int          mismatch_count;
    int          idle_cycles;
    bit          hold_receiver;
    bit          pause_sender;
    int          burst_left;
    int          gap_left;
    // accepted flag latched at the rising edge for the driver
    logic        s_ready_q;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic int unsigned used_states();
        int unsigned n;
        n = cfg_state_count;
        if (n < 1) n = 1;
        if (n > MAX_STATES) n = MAX_STATES;
        return n;
    endfunction

    function automatic logic [31:0] state_mask();
        return 32'((64'd1 << used_states()) - 1);
    endfunction

    function automatic logic [31:0] eps_closure(logic [31:0] set);
        logic [31:0] cur;
        logic [31:0] prev;
        cur = set & state_mask();
        do begin
            prev = cur;
            for (int i = 0; i < trans_count; i++)
                if (trans_store[i][0] && cur[trans_store[i][18:14]])
                    cur[trans_store[i][13:9]] = 1'b1;
            cur &= state_mask();
        end while (cur != prev);
        return cur;
    endfunction

    function automatic res_item_t match_step(cmd_item_t c);
        res_item_t r;
        logic [31:0] src;
        logic [31:0] nxt;
        int unsigned n;
        n = used_states();
        r = '{ST_OK, 1'b0, 1'b0, 1'b0};
        case (c.action)
            ACT_CLEAR: trans_count = 0;
            ACT_ADD: begin
                if (c.from_state >= n || c.to_state >= n) r.status = ST_RANGE;
                else if (trans_count >= MAX_TRANSITIONS) r.status = ST_FULL;
                else begin
                    trans_store[trans_count] = {c.from_state, c.to_state, c.symbol,
                                                c.is_epsilon};
                    trans_count++;
                end
            end
            ACT_BEGIN: begin
                if (cfg_start_state >= n) begin
                    r.status = ST_RANGE;
                    active_states = '0;
                    word_killed = 1'b1;
                end else begin
                    active_states = eps_closure(32'd1 << cfg_start_state);
                    word_killed = 1'b0;
                end
            end
            ACT_FEED: begin
                if (!word_killed) begin
                    src = eps_closure(active_states);
                    nxt = '0;
                    for (int i = 0; i < trans_count; i++)
                        if (!trans_store[i][0] && trans_store[i][8:1] == c.symbol
                            && src[trans_store[i][18:14]])
                            nxt[trans_store[i][13:9]] = 1'b1;
                    nxt &= state_mask();
                    active_states = nxt;
                    if (nxt == 0) word_killed = 1'b1;
                end
            end
            ACT_END: begin
                r.word_done = 1'b1;
                r.accepted = !word_killed
                    && (eps_closure(active_states) & cfg_final_mask) != 0;
            end
            default: ;
        endcase
        r.word_alive = !word_killed && (active_states & state_mask()) != 0;
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        mismatch_count++;
    endtask

    task automatic push_cmd(logic [2:0] a, int f, int t, int s, int e);
        cmd_item_t c;
        c = '{a, 5'(f), 5'(t), 8'(s), 1'(e)};
        pending_cmds.push_back(c);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_COUNT: cfg_state_count = val[5:0];
            REG_START: cfg_start_state = val[4:0];
            default: cfg_final_mask = val;
        endcase
    endtask

    task automatic wait_idle();
        while (pending_cmds.size() != 0 || s_valid || expected_results.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    // random automaton over ns states and a small alphabet, then words
    task automatic random_phase(int ns, int items);
        int k;
        k = 0;
        push_cmd(ACT_CLEAR, 0, 0, 0, 0);
        repeat ($urandom_range(1, 12)) begin
            push_cmd(ACT_ADD, $urandom_range(0, ns - 1), $urandom_range(0, ns - 1),
                     $urandom_range(0, 3) == 0 ? $urandom_range(0, 255)
                                               : $urandom_range(0, 3),
                     $urandom_range(0, 3) == 0);
            k++;
        end
        while (k < items) begin
            case ($urandom_range(0, 19))
                0: begin
                    push_cmd(3'($urandom_range(0, 7)), $urandom, $urandom, $urandom,
                             $urandom_range(0, 1));
                    k++;
                end
                1: begin
                    push_cmd(ACT_ADD, $urandom_range(0, 31), $urandom_range(0, 31),
                             $urandom_range(0, 3), $urandom_range(0, 1));
                    k++;
                end
                default: begin
                    if ($urandom_range(0, 5) != 0) begin
                        push_cmd(ACT_BEGIN, 0, 0, 0, 0);
                        k++;
                    end
                    repeat ($urandom_range(0, 5)) begin
                        push_cmd(ACT_FEED, $urandom, $urandom,
                                 $urandom_range(0, 9) == 0 ? $urandom_range(0, 255)
                                                           : $urandom_range(0, 3),
                                 $urandom_range(0, 1));
                        k++;
                    end
                    push_cmd(ACT_END, 0, 0, 0, 0);
                    k++;
                end
            endcase
        end
    endtask

    // driver: bursts and gaps
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
        end else if (!s_valid || s_ready_q) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_valid <= 1'b0;
            end else if (!pause_sender && pending_cmds.size() != 0) begin
                s_valid <= 1'b1;
                s_action <= pending_cmds[0].action;
                s_from_state <= pending_cmds[0].from_state;
                s_to_state <= pending_cmds[0].to_state;
                s_symbol <= pending_cmds[0].symbol;
                s_is_epsilon <= pending_cmds[0].is_epsilon;
                void'(pending_cmds.pop_front());
                if (burst_left > 0) burst_left <= burst_left - 1;
                else begin
                    burst_left <= $urandom_range(0, 15);
                    gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 6);
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) s_ready_q <= s_valid && s_ready;

    // receiver stall pattern
    always @(negedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else if (hold_receiver) m_ready <= 1'b0;
        else m_ready <= ($urandom_range(0, 7) != 0) || $urandom_range(0, 1);
    end

    // predictor on input acceptance, checker on result acceptance
    always @(posedge aclk) begin
        res_item_t want;
        cmd_item_t c;
        bit        moved;
        moved = 1'b0;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                c = '{s_action, s_from_state, s_to_state, s_symbol, s_is_epsilon};
                expected_results.push_back(match_step(c));
                moved = 1'b1;
            end
            if (m_valid && m_ready) begin
                moved = 1'b1;
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result item", 1, 0);
                end else begin
                    want = expected_results.pop_front();
                    if (m_status !== want.status)
                        report_mismatch("status", m_status, want.status);
                    if (m_word_done !== want.word_done)
                        report_mismatch("word_done", m_word_done, want.word_done);
                    if (m_accepted !== want.accepted)
                        report_mismatch("accepted", m_accepted, want.accepted);
                    if (m_word_alive !== want.word_alive)
                        report_mismatch("word_alive", m_word_alive, want.word_alive);
                end
            end
            idle_cycles <= moved ? 0 : idle_cycles + 1;
        end
    end

    always @(posedge aclk) begin
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired");
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_valid = 1'b0;
        s_action = '0;
        s_from_state = '0;
        s_to_state = '0;
        s_symbol = '0;
        s_is_epsilon = 1'b0;
        m_ready = 1'b0;
        hold_receiver = 1'b0;
        pause_sender = 1'b0;
        mismatch_count = 0;
        idle_cycles = 0;
        trans_count = 0;
        active_states = '0;
        word_killed = 1'b0;
        cfg_state_count = 6'd1;
        cfg_start_state = '0;
        cfg_final_mask = '0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: word before begin, one-state automaton
        push_cmd(ACT_FEED, 0, 0, 0, 0);
        push_cmd(ACT_END, 0, 0, 0, 0);
        wait_idle();
        write_reg(REG_COUNT, 32'd4);
        write_reg(REG_START, 32'd0);
        write_reg(REG_FINAL, 32'h0000_0008);
        push_cmd(ACT_ADD, 0, 1, 8'hff, 1);     // epsilon, label ignored
        push_cmd(ACT_ADD, 1, 2, 8'hff, 0);
        push_cmd(ACT_ADD, 2, 3, 8'h00, 0);
        push_cmd(ACT_ADD, 31, 0, 0, 0);        // out of range
        push_cmd(ACT_ADD, 0, 31, 0, 1);
        push_cmd(ACT_ADD, 4, 3, 0, 0);
        push_cmd(ACT_BEGIN, 0, 0, 0, 0);
        push_cmd(ACT_FEED, 0, 0, 8'hff, 0);
        push_cmd(ACT_FEED, 0, 0, 8'h00, 0);
        push_cmd(ACT_END, 0, 0, 0, 0);
        push_cmd(ACT_FEED, 0, 0, 8'h55, 0);    // kills
        push_cmd(ACT_FEED, 0, 0, 8'h00, 0);
        push_cmd(ACT_END, 0, 0, 0, 0);
        push_cmd(3'd5, 31, 31, 8'hff, 1);
        push_cmd(3'd7, 0, 0, 0, 0);
        push_cmd(ACT_BEGIN, 0, 0, 0, 0);
        push_cmd(ACT_FEED, 0, 0, 8'hff, 1);    // epsilon label never matches
        push_cmd(ACT_END, 0, 0, 0, 0);
        wait_idle();
        // bad start state, then shrunken state count
        write_reg(REG_START, 32'd31);
        push_cmd(ACT_BEGIN, 0, 0, 0, 0);
        push_cmd(ACT_END, 0, 0, 0, 0);
        wait_idle();
        write_reg(REG_START, 32'd0);
        write_reg(REG_COUNT, 32'd2);
        push_cmd(ACT_BEGIN, 0, 0, 0, 0);
        push_cmd(ACT_FEED, 0, 0, 8'hff, 0);
        push_cmd(ACT_END, 0, 0, 0, 0);
        wait_idle();

        // table full at the largest state count
        write_reg(REG_COUNT, 32'd63);
        write_reg(REG_FINAL, 32'h8000_0000);
        push_cmd(ACT_CLEAR, 0, 0, 0, 0);
        for (int i = 0; i < MAX_TRANSITIONS + 2; i++)
            push_cmd(ACT_ADD, i % 32, (i + 1) % 32, i % 4, 0);
        push_cmd(ACT_BEGIN, 0, 0, 0, 0);
        push_cmd(ACT_FEED, 0, 0, 1, 0);
        push_cmd(ACT_END, 0, 0, 0, 0);
        wait_idle();

        // random phases across configurations
        for (int p = 0; p < 8; p++) begin
            write_reg(REG_COUNT, p == 0 ? 32'd0 : p == 1 ? 32'd32 : $urandom_range(0, 63));
            write_reg(REG_START, $urandom_range(0, 3) == 0 ? $urandom_range(0, 31)
                                                           : $urandom_range(0, 3));
            write_reg(REG_FINAL, p == 2 ? 32'hffff_ffff : p == 3 ? 32'd0 : $urandom);
            random_phase(used_states(), 100);
            if (p == 4) begin
                hold_receiver = 1'b1;
                repeat (3000) @(posedge aclk);
                hold_receiver = 1'b0;
            end
            if (p == 5) begin
                while (pending_cmds.size() > 50) @(posedge aclk);
                pause_sender = 1'b1;
                while (expected_results.size() != 0) @(posedge aclk);
                pause_sender = 1'b0;
            end
            wait_idle();
        end

        repeat (DRAIN_CYCLES / 1000) @(posedge aclk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/nwm_pkg.sv
hw/rtl/nwm_ram.sv
hw/rtl/nwm_front.sv
hw/rtl/nwm_back.sv
hw/rtl/nfa_word_matcher_unit.sv
tb/sv/tb_top.sv
